FILE: hw/rtl/rfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int ARG_INDEX_W = 18;
    localparam int ERR_W       = 3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_LEN      = 3'd1;
    localparam logic [ERR_W-1:0] ERR_COUNT    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_OVERRUN  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRAILING = 3'd4;

    // Register indexes
    localparam logic REG_MAX_MESSAGE_LEN = 1'b0;
    localparam logic REG_MAX_ARG_COUNT   = 1'b1;

    // Register reset values, full 32-bit form; users truncate to their width
    localparam logic [31:0] MAX_MESSAGE_LEN_RST = 32'd33554432;
    localparam logic [31:0] MAX_ARG_COUNT_RST   = 32'd200000;

    // One classified request byte
    typedef struct packed {
        logic [BYTE_W-1:0]      arg_byte;
        logic                   is_arg_byte;
        logic [ARG_INDEX_W-1:0] arg_index;
        logic                   arg_last;
        logic                   request_done;
        logic [ERR_W-1:0]       error_code;
        logic                   closed;
    } rfc_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rfc_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module rfc_parser
    import rfc_pkg::*;
#(
    parameter int LEN_WIDTH   = 26,
    parameter int COUNT_WIDTH = 18,
    parameter int CFG_W       = 26
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic              new_connection,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    output rfc_result_t            result
);

    localparam logic [1:0] PH_LEN   = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_ALEN  = 2'd2;
    localparam logic [1:0] PH_DATA  = 2'd3;

    logic [LEN_WIDTH-1:0]   max_len_reg;
    logic [COUNT_WIDTH-1:0] max_cnt_reg;

    logic [1:0]             phase_reg, phase_next, phase_cur;
    logic [1:0]             cnt_reg, cnt_next, cnt_cur;
    logic [23:0]            shift_reg, shift_next, shift_cur;
    logic [LEN_WIDTH-1:0]   msg_reg, msg_next, msg_cur;
    logic [COUNT_WIDTH-1:0] args_reg, args_next, args_cur;
    logic [LEN_WIDTH-1:0]   abl_reg, abl_next, abl_cur;
    logic [COUNT_WIDTH-1:0] arg_reg, arg_next, arg_cur;
    logic                   closed_reg, closed_next, closed_cur;

    logic [31:0]            word;
    logic                   word_done;
    logic [LEN_WIDTH-1:0]   abl_dec;
    logic                   take_next;
    logic                   is_byte, last, done;
    logic [ERR_W-1:0]       err;

    // new_connection clears parse state ahead of this byte
    always_comb
    begin
        if (new_connection)
        begin
            phase_cur  = PH_LEN;
            cnt_cur    = '0;
            shift_cur  = '0;
            msg_cur    = '0;
            args_cur   = '0;
            abl_cur    = '0;
            arg_cur    = '0;
            closed_cur = 1'b0;
        end
        else
        begin
            phase_cur  = phase_reg;
            cnt_cur    = cnt_reg;
            shift_cur  = shift_reg;
            msg_cur    = msg_reg;
            args_cur   = args_reg;
            abl_cur    = abl_reg;
            arg_cur    = arg_reg;
            closed_cur = closed_reg;
        end
    end

    assign word      = {byte_in, shift_cur};
    assign word_done = (cnt_cur == 2'd3);
    assign abl_dec   = abl_cur - LEN_WIDTH'(1);

    always_comb
    begin
        phase_next  = phase_cur;
        cnt_next    = cnt_cur;
        shift_next  = shift_cur;
        msg_next    = msg_cur;
        args_next   = args_cur;
        abl_next    = abl_cur;
        arg_next    = arg_cur;
        closed_next = closed_cur;
        take_next   = 1'b0;
        is_byte     = 1'b0;
        last        = 1'b0;
        done        = 1'b0;
        err         = ERR_NONE;

        if (!closed_cur)
        begin
            // little-endian word gather for the three header phases
            if (phase_cur != PH_DATA)
            begin
                cnt_next = cnt_cur + 2'd1;
                unique case (cnt_cur)
                    2'd0: shift_next[7:0]   = byte_in;
                    2'd1: shift_next[15:8]  = byte_in;
                    2'd2: shift_next[23:16] = byte_in;
                    2'd3: shift_next        = '0;
                endcase
            end

            unique case (phase_cur)
                PH_LEN:
                begin
                    if (word_done)
                    begin
                        if (word > 32'(max_len_reg))
                        begin
                            err         = ERR_LEN;
                            closed_next = 1'b1;
                        end
                        else if (word < 32'd4)
                        begin
                            err         = ERR_OVERRUN;
                            closed_next = 1'b1;
                        end
                        else
                        begin
                            msg_next   = LEN_WIDTH'(word - 32'd4);
                            phase_next = PH_COUNT;
                        end
                    end
                end
                PH_COUNT:
                begin
                    if (word_done)
                    begin
                        if (word > 32'(max_cnt_reg))
                        begin
                            err         = ERR_COUNT;
                            closed_next = 1'b1;
                        end
                        else
                        begin
                            args_next = COUNT_WIDTH'(word);
                            arg_next  = '0;
                            take_next = 1'b1;
                        end
                    end
                end
                PH_ALEN:
                begin
                    if (word_done)
                    begin
                        if (word > 32'(msg_cur))
                        begin
                            err         = ERR_OVERRUN;
                            closed_next = 1'b1;
                        end
                        else
                        begin
                            // word fits in msg_cur here, so the cut is exact
                            msg_next = msg_cur - LEN_WIDTH'(word);
                            if (word == 32'd0)
                            begin
                                last      = 1'b1;
                                arg_next  = arg_cur + COUNT_WIDTH'(1);
                                args_next = args_cur - COUNT_WIDTH'(1);
                                take_next = 1'b1;
                            end
                            else
                            begin
                                abl_next   = LEN_WIDTH'(word);
                                phase_next = PH_DATA;
                            end
                        end
                    end
                end
                PH_DATA:
                begin
                    is_byte  = 1'b1;
                    abl_next = abl_dec;
                    if (abl_dec == '0)
                    begin
                        last      = 1'b1;
                        arg_next  = arg_cur + COUNT_WIDTH'(1);
                        args_next = args_cur - COUNT_WIDTH'(1);
                        take_next = 1'b1;
                    end
                end
            endcase

            // next argument length word, or end of request
            if (take_next)
            begin
                if (args_next == '0)
                begin
                    if (msg_next == '0)
                    begin
                        done       = 1'b1;
                        phase_next = PH_LEN;
                        arg_next   = '0;
                    end
                    else
                    begin
                        err         = ERR_TRAILING;
                        closed_next = 1'b1;
                    end
                end
                else if (msg_next < LEN_WIDTH'(4))
                begin
                    err         = ERR_OVERRUN;
                    closed_next = 1'b1;
                end
                else
                begin
                    msg_next   = msg_next - LEN_WIDTH'(4);
                    phase_next = PH_ALEN;
                end
            end
        end
    end

    always_comb
    begin
        result.arg_byte     = is_byte ? byte_in : '0;
        result.is_arg_byte  = is_byte;
        result.arg_index    = closed_cur ? '0 : ARG_INDEX_W'(arg_cur);
        result.arg_last     = last;
        result.request_done = done;
        result.error_code   = err;
        result.closed       = closed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_MESSAGE_LEN_RST[LEN_WIDTH-1:0];
            max_cnt_reg <= MAX_ARG_COUNT_RST[COUNT_WIDTH-1:0];
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_MESSAGE_LEN: max_len_reg <= cfg_data[LEN_WIDTH-1:0];
                REG_MAX_ARG_COUNT:   max_cnt_reg <= cfg_data[COUNT_WIDTH-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN;
            cnt_reg    <= '0;
            shift_reg  <= '0;
            msg_reg    <= '0;
            args_reg   <= '0;
            abl_reg    <= '0;
            arg_reg    <= '0;
            closed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            shift_reg  <= shift_next;
            msg_reg    <= msg_next;
            args_reg   <= args_next;
            abl_reg    <= abl_next;
            arg_reg    <= arg_next;
            closed_reg <= closed_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.error_code != ERR_NONE) |=> closed_reg)
        else $error("error did not close the stream");

    a_done_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.request_done) |=> (phase_reg == PH_LEN && arg_reg == '0))
        else $error("request_done left parser mid-request");

    a_closed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && closed_reg && !new_connection) |=>
            (closed_reg && $stable(phase_reg) && $stable(msg_reg)))
        else $error("closed stream changed parse state");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/rfc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rfc_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  empty,
    output logic [WIDTH-1:0]      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/request_frame_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// A request byte's result is written into the result queue at the edge that accepts the byte.
// Throughput: one byte per cycle while in_stall is low; the parse step for a byte completes in the cycle it is taken.
// A two-entry result queue sits between parser and output; in_stall rises only when it is full.
// Reset (rst_n low, async): parse state cleared, stream open, queue empty,
// limits back to 32 MiB and 200000 arguments.

module request_frame_checker
    import rfc_pkg::*;
#(
    parameter int LEN_WIDTH   = 26,
    parameter int COUNT_WIDTH = 18
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // request byte channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [BYTE_W-1:0]     byte_in,
    input  wire logic                  new_connection,

    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [BYTE_W-1:0]          arg_byte,
    output logic                       is_arg_byte,
    output logic [ARG_INDEX_W-1:0]     arg_index,
    output logic                       arg_last,
    output logic                       request_done,
    output logic [ERR_W-1:0]           error_code,
    output logic                       closed,

    // configuration write port
    input  wire logic                  cfg_write,
    input  wire logic                  cfg_index,
    input  wire logic [((LEN_WIDTH > COUNT_WIDTH) ? LEN_WIDTH : COUNT_WIDTH)-1:0] cfg_data
);

    localparam int CFG_W = (LEN_WIDTH > COUNT_WIDTH) ? LEN_WIDTH : COUNT_WIDTH;
    localparam int RES_W = $bits(rfc_result_t);

    logic        in_accept;
    logic        fifo_full;
    logic        fifo_empty;
    logic        out_pop;
    rfc_result_t parsed;
    rfc_result_t head;

    // Front: byte parser; its state advances only on an accepted request byte.
    assign in_accept = in_valid && !in_stall;

    rfc_parser #(
        .LEN_WIDTH   (LEN_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .CFG_W       (CFG_W)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .byte_in        (byte_in),
        .new_connection (new_connection),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result         (parsed)
    );

    // Back: result queue drives the output channel from registers.
    assign out_pop = out_valid && !out_stall;

    rfc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (parsed),
        .pop       (out_pop),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .head      (head)
    );

    assign in_stall  = fifo_full;
    assign out_valid = !fifo_empty;

    assign arg_byte     = head.arg_byte;
    assign is_arg_byte  = head.is_arg_byte;
    assign arg_index    = head.arg_index;
    assign arg_last     = head.arg_last;
    assign request_done = head.request_done;
    assign error_code   = head.error_code;
    assign closed       = head.closed;

endmodule

`default_nettype wire

FILE: tb/sv/request_frame_watch.sv
`timescale 1ns / 1ps

// Watches both request_frame_checker channels, keeps its own model of the framer,
// and compares each result against the oldest pending prediction.
module request_frame_watch
    import rfc_pkg::*;
#(
    parameter int LEN_WIDTH   = 26,
    parameter int COUNT_WIDTH = 18,
    parameter int CFG_W       = (LEN_WIDTH > COUNT_WIDTH) ? LEN_WIDTH : COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [BYTE_W-1:0]      byte_in,
    input  logic                   new_connection,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [BYTE_W-1:0]      arg_byte,
    input  logic                   is_arg_byte,
    input  logic [ARG_INDEX_W-1:0] arg_index,
    input  logic                   arg_last,
    input  logic                   request_done,
    input  logic [ERR_W-1:0]       error_code,
    input  logic                   closed,
    input  logic                   cfg_write,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output int                     mismatches,
    output int                     awaiting,
    output int                     results_checked,
    output int                     requests_done,
    output int                     errors_raised
);

    typedef enum logic [1:0] {WAIT_LEN, WAIT_COUNT, WAIT_ARG_LEN, ARG_DATA} frame_phase_t;

    logic [LEN_WIDTH-1:0]   len_limit;
    logic [COUNT_WIDTH-1:0] count_limit;

    frame_phase_t           ph;
    logic [1:0]             word_bytes;
    logic [31:0]            word_acc;
    logic [LEN_WIDTH-1:0]   body_left;
    logic [COUNT_WIDTH-1:0] args_to_go;
    logic [LEN_WIDTH-1:0]   payload_left;
    logic [COUNT_WIDTH-1:0] arg_no;
    logic                   shut;
    logic                   frame_done;

    rfc_result_t            byte_verdicts[$];

    function automatic void clear_frame();
        ph           = WAIT_LEN;
        word_bytes   = '0;
        word_acc     = '0;
        body_left    = '0;
        args_to_go   = '0;
        payload_left = '0;
        arg_no       = '0;
        shut         = 1'b0;
    endfunction

    // Either start the next argument length word or close out the request.
    function automatic logic [ERR_W-1:0] open_next_field();
        if (args_to_go == '0) begin
            if (body_left == '0) begin
                frame_done = 1'b1;
                ph         = WAIT_LEN;
                arg_no     = '0;
                return ERR_NONE;
            end
            return ERR_TRAILING;
        end
        if (body_left < LEN_WIDTH'(4))
            return ERR_OVERRUN;
        body_left = body_left - LEN_WIDTH'(4);
        ph        = WAIT_ARG_LEN;
        return ERR_NONE;
    endfunction

    function automatic logic [ERR_W-1:0] close_arg();
        arg_no     = arg_no + 1'b1;
        args_to_go = args_to_go - 1'b1;
        return open_next_field();
    endfunction

    function automatic rfc_result_t predict_frame_byte(input logic [7:0] b, input logic fresh);
        rfc_result_t      r;
        logic [31:0]      word;
        logic             word_ready;
        logic [ERR_W-1:0] err;
        r          = '0;
        err        = ERR_NONE;
        word       = '0;
        word_ready = 1'b0;
        frame_done = 1'b0;
        if (fresh)
            clear_frame();
        r.arg_index = ARG_INDEX_W'(arg_no);
        if (shut) begin
            r.arg_index = '0;
        end
        else begin
            if (ph != ARG_DATA) begin
                word_acc   = word_acc | ({24'd0, b} << (8 * word_bytes));
                word_bytes = word_bytes + 1'b1;
                if (word_bytes == 2'd0) begin
                    word       = word_acc;
                    word_acc   = '0;
                    word_ready = 1'b1;
                end
            end
            case (ph)
                WAIT_LEN:
                    if (word_ready) begin
                        if (word > len_limit)
                            err = ERR_LEN;
                        else if (word < 32'd4)
                            err = ERR_OVERRUN;
                        else begin
                            body_left = LEN_WIDTH'(word - 32'd4);
                            ph        = WAIT_COUNT;
                        end
                    end
                WAIT_COUNT:
                    if (word_ready) begin
                        if (word > count_limit)
                            err = ERR_COUNT;
                        else begin
                            args_to_go = COUNT_WIDTH'(word);
                            arg_no     = '0;
                            err        = open_next_field();
                        end
                    end
                WAIT_ARG_LEN:
                    if (word_ready) begin
                        if (word > body_left)
                            err = ERR_OVERRUN;
                        else begin
                            body_left = body_left - LEN_WIDTH'(word);
                            if (word == 32'd0) begin
                                r.arg_last = 1'b1;
                                err        = close_arg();
                            end
                            else begin
                                payload_left = LEN_WIDTH'(word);
                                ph           = ARG_DATA;
                            end
                        end
                    end
                ARG_DATA: begin
                    r.is_arg_byte = 1'b1;
                    r.arg_byte    = b;
                    payload_left  = payload_left - 1'b1;
                    if (payload_left == '0) begin
                        r.arg_last = 1'b1;
                        err        = close_arg();
                    end
                end
            endcase
            if (err != ERR_NONE)
                shut = 1'b1;
        end
        r.request_done = frame_done;
        r.error_code   = err;
        r.closed       = shut;
        return r;
    endfunction

    function automatic string verdict_text(input rfc_result_t r);
        return $sformatf("byte=%02h arg=%b idx=%0d last=%b done=%b err=%0d closed=%b",
                         r.arg_byte, r.is_arg_byte, r.arg_index, r.arg_last,
                         r.request_done, r.error_code, r.closed);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        rfc_result_t seen;
        rfc_result_t want;
        if (!rst_n) begin
            len_limit       = LEN_WIDTH'(MAX_MESSAGE_LEN_RST);
            count_limit     = COUNT_WIDTH'(MAX_ARG_COUNT_RST);
            frame_done      = 1'b0;
            clear_frame();
            byte_verdicts.delete();
            mismatches      = 0;
            awaiting        = 0;
            results_checked = 0;
            requests_done   = 0;
            errors_raised   = 0;
        end
        else begin
            // results first, so a result popped at this edge is matched before the byte taken at this edge is predicted
            if (out_valid && !out_stall) begin
                seen = {arg_byte, is_arg_byte, arg_index, arg_last,
                        request_done, error_code, closed};
                if (byte_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request pending: %s",
                                 $realtime, verdict_text(seen));
                end
                else begin
                    want = byte_verdicts.pop_front();
                    results_checked++;
                    if (want.request_done)
                        requests_done++;
                    if (want.error_code != ERR_NONE)
                        errors_raised++;
                    if (seen.arg_byte !== want.arg_byte ||
                        seen.is_arg_byte !== want.is_arg_byte ||
                        seen.arg_index !== want.arg_index ||
                        seen.arg_last !== want.arg_last ||
                        seen.request_done !== want.request_done ||
                        seen.error_code !== want.error_code ||
                        seen.closed !== want.closed) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch on result %0d\n  expected %s\n  actual   %s",
                                     $realtime, results_checked,
                                     verdict_text(want), verdict_text(seen));
                    end
                end
            end
            if (in_valid && !in_stall)
                byte_verdicts.insert(byte_verdicts.size(),
                                     predict_frame_byte(byte_in, new_connection));
            if (cfg_write) begin
                if (cfg_index == REG_MAX_MESSAGE_LEN)
                    len_limit = cfg_data[LEN_WIDTH-1:0];
                else
                    count_limit = cfg_data[COUNT_WIDTH-1:0];
            end
            awaiting = byte_verdicts.size();
        end
    end

endmodule

FILE: tb/sv/tb_request_frame_checker.sv
`timescale 1ns / 1ps

module tb_request_frame_checker;
    import rfc_pkg::*;

    localparam int LEN_WIDTH     = 26;
    localparam int COUNT_WIDTH   = 18;
    localparam int CFG_W         = (LEN_WIDTH > COUNT_WIDTH) ? LEN_WIDTH : COUNT_WIDTH;
    // margin for the two-deep result queue
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SEGMENTS      = 5;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      byte_in;
    logic                   new_connection;
    logic                   out_valid;
    logic                   out_stall;
    logic [BYTE_W-1:0]      arg_byte;
    logic                   is_arg_byte;
    logic [ARG_INDEX_W-1:0] arg_index;
    logic                   arg_last;
    logic                   request_done;
    logic [ERR_W-1:0]       error_code;
    logic                   closed;
    logic                   cfg_write;
    logic                   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int mismatches;
    int awaiting;
    int results_checked;
    int requests_done;
    int errors_raised;

    // One byte of the connection stream plus its new-connection flag.
    typedef struct packed {
        logic       fresh;
        logic [7:0] value;
    } stream_byte_t;

    stream_byte_t outgoing[$];

    int   send_idle_pct;
    int   recv_stall_pct;
    int   bytes_sent;
    logic stream_dirty;     // last request may have left the parser mid-frame or closed

    // Limit settings swept after the directed part; the extremes come first.
    int seg_len_limit [SEGMENTS] = '{33554432, 0, 33554432, 48, 200};
    int seg_cnt_limit [SEGMENTS] = '{200000, 0, 0, 3, 12};
    int seg_profile   [SEGMENTS] = '{0, 1, 1, 1, 2};
    int seg_bytes     [SEGMENTS] = '{500, 40, 60, 450, 550};

    request_frame_checker uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_in        (byte_in),
        .new_connection (new_connection),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .arg_byte       (arg_byte),
        .is_arg_byte    (is_arg_byte),
        .arg_index      (arg_index),
        .arg_last       (arg_last),
        .request_done   (request_done),
        .error_code     (error_code),
        .closed         (closed),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    request_frame_watch #(
        .LEN_WIDTH   (LEN_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_watch (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_in         (byte_in),
        .new_connection  (new_connection),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .arg_byte        (arg_byte),
        .is_arg_byte     (is_arg_byte),
        .arg_index       (arg_index),
        .arg_last        (arg_last),
        .request_done    (request_done),
        .error_code      (error_code),
        .closed          (closed),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .results_checked (results_checked),
        .requests_done   (requests_done),
        .errors_raised   (errors_raised)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side backpressure, redrawn every falling edge so stalls land on
    // every phase of the parse.
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Queue a 32-bit word little-endian; only its first byte may carry new_connection.
    task automatic add_word(input logic [31:0] w, input logic fresh);
        outgoing.insert(outgoing.size(), {fresh, w[7:0]});
        outgoing.insert(outgoing.size(), {1'b0, w[15:8]});
        outgoing.insert(outgoing.size(), {1'b0, w[23:16]});
        outgoing.insert(outgoing.size(), {1'b0, w[31:24]});
    endtask

    // Build one request. About two thirds are well formed with random payload;
    // the rest have a padded or short body, an absurd length or count, get cut
    // off mid-frame, or are plain line noise.
    task automatic add_request();
        int          pick;
        int          n_args;
        int          extra;
        int          start_size;
        int          arg_lens[$];
        logic [31:0] body;
        logic [31:0] count_word;
        logic        fresh;
        pick  = $urandom_range(99);
        fresh = stream_dirty || ($urandom_range(9) == 0);
        if (pick >= 94) begin
            extra = $urandom_range(1, 12);
            repeat (extra)
                outgoing.insert(outgoing.size(), {($urandom_range(7) == 0), 8'($urandom)});
            stream_dirty = 1'b1;
            return;
        end
        n_args = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(4);
        body   = 32'd4;
        repeat (n_args) begin
            arg_lens.insert(arg_lens.size(), ($urandom_range(15) == 0) ? $urandom_range(64)
                                                                       : $urandom_range(6));
            body = body + 32'd4 + arg_lens[$];
        end
        count_word = n_args;
        extra      = 0;
        if (pick >= 65 && pick < 72) begin
            // trailing bytes after the last argument
            extra = $urandom_range(1, 3);
            body  = body + extra;
        end
        else if (pick >= 72 && pick < 79)
            body = body - $urandom_range(1, (body < 6) ? body : 6);
        else if (pick >= 79 && pick < 84)
            body = $urandom;
        else if (pick >= 84 && pick < 89)
            count_word = $urandom;
        start_size = outgoing.size();
        add_word(body, fresh);
        add_word(count_word, 1'b0);
        foreach (arg_lens[i]) begin
            add_word(arg_lens[i], 1'b0);
            repeat (arg_lens[i])
                outgoing.insert(outgoing.size(), {1'b0, 8'($urandom)});
        end
        repeat (extra)
            outgoing.insert(outgoing.size(), {1'b0, 8'($urandom)});
        if (pick >= 89) begin
            extra = $urandom_range(1, outgoing.size() - start_size - 1);
            repeat (extra)
                void'(outgoing.pop_back());
        end
        stream_dirty = (pick >= 65);
    endtask

    // Push queued bytes one byte per handshake. Called and returns at a
    // falling edge; in_valid stays high between back-to-back requests.
    task automatic send_outgoing();
        stream_byte_t sb;
        while (outgoing.size() > 0) begin
            sb = outgoing.pop_front();
            while ($urandom_range(99) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid       <= 1'b1;
            byte_in        <= sb.value;
            new_connection <= sb.fresh;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            bytes_sent++;
            @(negedge clk);
        end
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic settle();
        int spins;
        spins = 0;
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaiting != 0 && spins < DRAIN_LIMIT) begin
            @(negedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Both limit registers, back to back; write enable held across the pair.
    task automatic set_limits(input logic [CFG_W-1:0] len_cap,
                              input logic [CFG_W-1:0] count_cap);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAX_MESSAGE_LEN;
        cfg_data  <= len_cap;
        @(negedge clk);
        cfg_index <= REG_MAX_ARG_COUNT;
        cfg_data  <= count_cap;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        int seg_sent;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_in        = '0;
        new_connection = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = REG_MAX_MESSAGE_LEN;
        cfg_data       = '0;
        send_idle_pct  = 28;
        recv_stall_pct = 50;
        bytes_sent     = 0;
        stream_dirty   = 1'b0;

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset limits:
        //   all-ones length -> over limit, then one byte into the closed stream
        //   zero length -> too short to hold the count
        //   empty body with zero args -> done
        //   same stream, all-ones count -> count over limit
        add_word(32'hFFFF_FFFF, 1'b1);
        outgoing.insert(outgoing.size(), {1'b0, 8'h5A});
        add_word(32'd0, 1'b1);
        add_word(32'd4, 1'b1);
        add_word(32'd0, 1'b0);
        add_word(32'd4, 1'b0);
        add_word(32'hFFFF_FFFF, 1'b0);
        send_outgoing();
        stream_dirty = 1'b1;

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle();
            set_limits(CFG_W'(seg_len_limit[seg]), CFG_W'(seg_cnt_limit[seg]));
            case (seg_profile[seg])
                0: begin send_idle_pct = 28; recv_stall_pct = 50; end
                1: begin send_idle_pct = 50; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            seg_sent = 0;
            while (seg_sent < seg_bytes[seg]) begin
                add_request();
                seg_sent += outgoing.size();
                send_outgoing();
            end
        end
        settle();

        $display("Checked %0d results for %0d request bytes over %0d limit settings",
                 results_checked, bytes_sent, SEGMENTS + 1);
        $display("%0d requests completed cleanly, %0d closed by an error",
                 requests_done, errors_raised);
        if (mismatches == 0 && awaiting == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
